>>> hdl/rtpl_pkg.sv
// Shared constants and types of the ramped two-pole low-pass block.
`default_nettype none
package rtpl_pkg;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [16:0] Q16_ONE = 17'h1_0000;
	localparam logic [6:0]  REFRESH_INTERVAL = 7'd64;
	localparam logic [13:0] RAMP_MIN = 14'd400;
	localparam logic [13:0] RAMP_MAX = 14'd9600;
	localparam logic [13:0] RAMP_RESET = 14'd2205;
	localparam int DIV_BITS = 44;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

	localparam logic [1:0] CFG_ALPHA = 2'd0;
	localparam logic [1:0] CFG_WET = 2'd1;
	localparam logic [1:0] CFG_RAMP = 2'd2;
	localparam logic [1:0] CFG_CHANNELS = 2'd3;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [13:0]         divisor;
	} div_req_t;

	typedef struct packed {
		logic        start;
		logic        clear;
		logic        primed;
		logic [30:0] alpha;
		logic [16:0] wet;
	} lane_ctl_t;

endpackage
`default_nettype wire

>>> hdl/rtpl_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp interpolation.
`default_nettype none
module rtpl_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtpl_pkg::div_req_t req,
	output logic                   done,
	output logic [rtpl_pkg::DIV_BITS-1:0] quotient
);
	import rtpl_pkg::*;

	logic [13:0]          rem_q;
	logic [13:0]          dsr_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [14:0]          trial;
	logic [14:0]          diff;

	always_comb begin
		trial = {rem_q, quo_q[DIV_BITS-1]};
		diff = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			if (!diff[14]) begin
				rem_q <= diff[13:0];
			end else begin
				rem_q <= trial[13:0];
			end
			quo_q <= {quo_q[DIV_BITS-2:0], ~diff[14]};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> hdl/rtpl_lane.sv
// One channel lane: two cascaded one-pole stages and the wet cross-fade.
`default_nettype none
module rtpl_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rtpl_pkg::lane_ctl_t ctl,
	input  wire logic signed [15:0]  dry,
	output logic                     done,
	output logic signed [15:0]       res
);
	import rtpl_pkg::*;

	typedef enum logic [6:0] {
		P_IDLE = 7'b000_0001,
		P_M1   = 7'b000_0010,
		P_A1   = 7'b000_0100,
		P_M2   = 7'b000_1000,
		P_A2   = 7'b001_0000,
		P_M3   = 7'b010_0000,
		P_A3   = 7'b100_0000
	} phase_t;

	phase_t phase_q;
	logic   rnd_q;
	logic signed [31:0] s1_q, s2_q, base_q, bfin_q;
	logic        neg_q;
	logic [62:0] prod_q;
	logic        done_q;
	logic signed [15:0] res_q;

	logic signed [31:0] x, base;
	logic signed [32:0] dif;
	logic [31:0] mag;
	logic [30:0] coef;
	logic [32:0] r;
	logic [33:0] rs;
	logic [31:0] sum;
	logic        wet_mid;
	logic [32:0] bm;
	logic [16:0] rr;

	always_comb begin
		x = {dry, 16'h0000};
		base = x;
		coef = ctl.alpha;
		dif = {x[31], x} - {base[31], base};
		case (phase_q)
			P_M1: begin
				base = ctl.primed ? s1_q : x;
				dif = {x[31], x} - {base[31], base};
			end
			P_M2: begin
				base = ctl.primed ? s2_q : x;
				dif = {s1_q[31], s1_q} - {base[31], base};
			end
			P_M3: begin
				base = x;
				dif = {s2_q[31], s2_q} - {x[31], x};
				coef = {14'd0, ctl.wet};
			end
			default: begin
			end
		endcase
		mag = dif[32] ? 32'(-dif) : dif[31:0];
		if (phase_q == P_A3) begin
			r = 33'((prod_q + 63'h8000) >> 16);
		end else begin
			r = 33'((prod_q + 63'h2000_0000) >> 30);
		end
		rs = neg_q ? -{1'b0, r} : {1'b0, r};
		sum = 32'({{2{base_q[31]}}, base_q} + rs);
		wet_mid = (ctl.wet != 17'd0) && (ctl.wet != Q16_ONE);
		bm = bfin_q[31] ? 33'(-{bfin_q[31], bfin_q}) : {1'b0, bfin_q};
		rr = 17'((bm + 33'h8000) >> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			rnd_q <= 1'b0;
			done_q <= 1'b0;
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			done_q <= 1'b0;
			rnd_q <= 1'b0;
			if (ctl.clear) begin
				s1_q <= '0;
				s2_q <= '0;
			end
			case (phase_q)
				P_IDLE: if (ctl.start) phase_q <= P_M1;
				P_M1: phase_q <= P_A1;
				P_A1: begin
					s1_q <= sum;
					phase_q <= P_M2;
				end
				P_M2: phase_q <= P_A2;
				P_A2: begin
					s2_q <= sum;
					if (wet_mid) begin
						phase_q <= P_M3;
					end else begin
						rnd_q <= 1'b1;
						phase_q <= P_IDLE;
					end
				end
				P_M3: phase_q <= P_A3;
				P_A3: begin
					rnd_q <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
			if (rnd_q) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_M1 || phase_q == P_M2 || phase_q == P_M3) begin
			prod_q <= mag * coef;
			neg_q <= dif[32];
			base_q <= base;
		end
		if (phase_q == P_A2 || phase_q == P_A3) bfin_q <= sum;
		if (rnd_q) begin
			if (ctl.wet == 17'd0) begin
				res_q <= dry;
			end else begin
				res_q <= bfin_q[31] ? 16'(-rr) : rr[15:0];
			end
		end
	end

	assign done = done_q;
	assign res = res_q;
endmodule
`default_nettype wire

>>> hdl/ramped_two_pole_lowpass_top.sv
// Top level of the ramped two-pole low-pass: sequencer, ramps, lanes, merge.
// Usage:
//  Input channel: in_valid/in_stall carries one stereo frame per request
//  (sample_left, sample_right, clear_history). Output channel: out_valid/
//  out_stall carries out_left, out_right, bypassed, one result per frame.
//  Configuration: cfg_we/cfg_idx/cfg_data, written while the block is idle.
//  A frame is processed alone: latch and clear in the accept cycle, then an
//  optional coefficient interpolation and an optional wet interpolation,
//  each one pass of the shared serial divider (44 quotient bits), then the
//  lanes run in parallel, the second only when two channels are configured.
//  The next frame can be taken in the cycle in which out_valid rises.
//  Reset clears filter history, ramps and configuration to defaults.
//  When the receiver stalls, the finished result holds in the output
//  register and the next frame may be accepted and run until its result is
//  ready, then it waits for the output register to free.
`default_nettype none
module ramped_two_pole_lowpass_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [30:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] sample_left,
	input  wire logic signed [15:0] sample_right,
	input  wire logic               clear_history,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      out_left,
	output logic signed [15:0]      out_right,
	output logic                    bypassed
);
	import rtpl_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ASTEP = 8'b0000_0010,
		S_ADIV  = 8'b0000_0100,
		S_WSTEP = 8'b0000_1000,
		S_WDIV  = 8'b0001_0000,
		S_CHK   = 8'b0010_0000,
		S_LANE  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [30:0] alpha_tgt_q;
	logic        wet_en_q;
	logic [13:0] ramp_q;
	logic        two_q;

	logic        hv_q;
	logic [30:0] acur_q, astart_q, alat_q;
	logic [13:0] astep_q;
	logic [6:0]  rc_q;
	logic [16:0] wcur_q, wstart_q;
	logic        goal_q;
	logic [13:0] wstep_q;

	logic signed [15:0] dry_l_q, dry_r_q;
	logic signed [15:0] res_l_q, res_r_q;
	logic        byp_q;
	logic        div_neg_q;
	logic        lane_clear_q;

	logic        out_valid_q;
	logic signed [15:0] out_l_q, out_r_q;
	logic        out_b_q;

	logic        accept;
	logic        c_hv;
	logic [30:0] c_acur, c_astart;
	logic [13:0] c_astep;
	logic [6:0]  c_rc;
	logic [16:0] c_wcur, c_wstart;
	logic [13:0] c_wstep;
	logic [30:0] n_acur, n_astart, n_alat;
	logic [13:0] n_astep, n_wstep;
	logic [6:0]  n_rc;
	logic [16:0] n_wstart;
	logic        n_goal;
	logic        a_chg, w_chg;

	logic        quiet;
	logic [13:0] astep_n, wstep_n;
	logic [6:0]  rc_n;
	logic signed [31:0] adiff;
	logic [30:0] amag;
	logic [44:0] aprod;
	logic [16:0] gval;
	logic signed [17:0] wdiff;
	logic [16:0] wmag;
	logic [30:0] wprod;
	logic        a_refresh;
	logic [31:0] q32;
	logic [31:0] qs;
	logic [31:0] a_sum;
	logic [17:0] w_sum;
	logic [13:0] ramp_sat;
	logic        out_free;

	div_req_t    dreq;
	logic        div_done;
	logic [DIV_BITS-1:0] div_quo;
	lane_ctl_t   ctl0, ctl1;
	logic        done0, done1;
	logic signed [15:0] lres0, lres1;

	assign accept = (state_q == S_IDLE) && in_valid;
	assign in_stall = (state_q != S_IDLE);
	assign quiet = (wcur_q == 17'd0) && !goal_q;
	assign out_free = !out_valid_q || !out_stall;
	assign gval = goal_q ? Q16_ONE : 17'd0;

	always_comb begin
		ramp_sat = cfg_data[13:0];
		if (ramp_sat < RAMP_MIN) ramp_sat = RAMP_MIN;
		if (ramp_sat > RAMP_MAX) ramp_sat = RAMP_MAX;
	end

	// clear, then latch
	always_comb begin
		c_hv = hv_q;
		c_acur = acur_q;
		c_astart = astart_q;
		c_astep = astep_q;
		c_rc = rc_q;
		c_wcur = wcur_q;
		c_wstart = wstart_q;
		c_wstep = wstep_q;
		if (clear_history) begin
			c_hv = 1'b0;
			c_acur = alat_q;
			c_astart = alat_q;
			c_astep = ramp_q;
			c_rc = 7'd0;
			c_wcur = 17'd0;
			c_wstart = 17'd0;
			c_wstep = 14'd0;
		end
		n_acur = c_acur;
		n_astart = c_astart;
		n_astep = c_astep;
		n_rc = c_rc;
		n_wstart = c_wstart;
		n_wstep = c_wstep;
		n_alat = alat_q;
		n_goal = goal_q;
		a_chg = alpha_tgt_q != alat_q;
		w_chg = wet_en_q != goal_q;
		if (a_chg || w_chg) begin
			if (c_wcur == 17'd0 && !goal_q) begin
				n_acur = alpha_tgt_q;
				n_astart = alpha_tgt_q;
				n_astep = ramp_q;
			end else if (a_chg) begin
				n_astart = c_acur;
				n_astep = 14'd0;
				n_rc = REFRESH_INTERVAL;
			end
			n_alat = alpha_tgt_q;
			if (w_chg) begin
				n_wstart = c_wcur;
				n_wstep = 14'd0;
				n_goal = wet_en_q;
			end
		end
	end

	// ramp step arithmetic
	always_comb begin
		astep_n = astep_q + 14'd1;
		wstep_n = wstep_q + 14'd1;
		rc_n = rc_q - 7'd1;
		a_refresh = (rc_n == 7'd0) || (astep_n == ramp_q);
		adiff = $signed({1'b0, alat_q}) - $signed({1'b0, astart_q});
		amag = adiff[31] ? 31'(-adiff) : adiff[30:0];
		aprod = amag * astep_n;
		wdiff = $signed({1'b0, gval}) - $signed({1'b0, wstart_q});
		wmag = wdiff[17] ? 17'(-wdiff) : wdiff[16:0];
		wprod = wmag * wstep_n;
		q32 = div_quo[31:0];
		qs = div_neg_q ? -q32 : q32;
		a_sum = {1'b0, astart_q} + qs;
		w_sum = {1'b0, wstart_q} + qs[17:0];
		dreq.start = 1'b0;
		dreq.divisor = ramp_q;
		dreq.dividend = aprod[DIV_BITS-1:0];
		if (state_q == S_ASTEP) begin
			dreq.start = !quiet && (astep_q < ramp_q) && a_refresh;
		end else if (state_q == S_WSTEP) begin
			dreq.start = wstep_q < ramp_q;
			dreq.dividend = {{(DIV_BITS-31){1'b0}}, wprod};
		end
	end

	always_comb begin
		ctl0.start = (state_q == S_CHK) && !quiet;
		ctl0.clear = lane_clear_q;
		ctl0.primed = hv_q;
		ctl0.alpha = acur_q;
		ctl0.wet = wcur_q;
		ctl1 = ctl0;
		ctl1.start = ctl0.start && two_q;
	end

	rtpl_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(div_done), .quotient(div_quo)
	);

	rtpl_lane u_lane0 (
		.clk(clk), .arst_n(arst_n), .ctl(ctl0), .dry(dry_l_q), .done(done0), .res(lres0)
	);

	rtpl_lane u_lane1 (
		.clk(clk), .arst_n(arst_n), .ctl(ctl1), .dry(dry_r_q), .done(done1), .res(lres1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alpha_tgt_q <= '0;
			wet_en_q <= 1'b0;
			ramp_q <= RAMP_RESET;
			two_q <= 1'b1;
			hv_q <= 1'b0;
			acur_q <= '0;
			astart_q <= '0;
			alat_q <= '0;
			astep_q <= '0;
			rc_q <= '0;
			wcur_q <= '0;
			wstart_q <= '0;
			goal_q <= 1'b0;
			wstep_q <= '0;
			lane_clear_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			lane_clear_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ALPHA: alpha_tgt_q <= (cfg_data > Q30_ONE) ? Q30_ONE : cfg_data;
					CFG_WET: wet_en_q <= cfg_data[0];
					CFG_RAMP: ramp_q <= ramp_sat;
					CFG_CHANNELS: two_q <= cfg_data[1];
					default: begin
					end
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lane_clear_q <= clear_history;
						hv_q <= c_hv;
						acur_q <= n_acur;
						astart_q <= n_astart;
						alat_q <= n_alat;
						astep_q <= n_astep;
						rc_q <= n_rc;
						wcur_q <= c_wcur;
						wstart_q <= n_wstart;
						wstep_q <= n_wstep;
						goal_q <= n_goal;
						state_q <= S_ASTEP;
					end
				end
				S_ASTEP: begin
					if (quiet) begin
						state_q <= S_OUT;
					end else if (astep_q < ramp_q) begin
						astep_q <= astep_n;
						if (a_refresh) begin
							rc_q <= REFRESH_INTERVAL;
							state_q <= S_ADIV;
						end else begin
							rc_q <= rc_n;
							state_q <= S_WSTEP;
						end
					end else begin
						state_q <= S_WSTEP;
					end
				end
				S_ADIV: begin
					if (div_done) begin
						acur_q <= a_sum[30:0];
						state_q <= S_WSTEP;
					end
				end
				S_WSTEP: begin
					if (wstep_q < ramp_q) begin
						wstep_q <= wstep_n;
						state_q <= S_WDIV;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_WDIV: begin
					if (div_done) begin
						wcur_q <= w_sum[16:0];
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (quiet) begin
						hv_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_LANE;
					end
				end
				S_LANE: begin
					if (done0) begin
						hv_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// input latch, merge of lane or bypass results, output register
	always_ff @(posedge clk) begin
		if (accept) begin
			dry_l_q <= sample_left;
			dry_r_q <= sample_right;
		end
		if (dreq.start) div_neg_q <= (state_q == S_ASTEP) ? adiff[31] : wdiff[17];
		if ((state_q == S_ASTEP || state_q == S_CHK) && quiet) begin
			res_l_q <= dry_l_q;
			res_r_q <= dry_r_q;
			byp_q <= 1'b1;
		end
		if (state_q == S_LANE && done0) begin
			res_l_q <= lres0;
			res_r_q <= (two_q && done1) ? lres1 : dry_r_q;
			byp_q <= 1'b0;
		end
		if (state_q == S_OUT && out_free) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
			out_b_q <= byp_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left = out_l_q;
	assign out_right = out_r_q;
	assign bypassed = out_b_q;
endmodule
`default_nettype wire
